// ===== hdl/cstt_pkg.sv =====
// shared types, codes and constants for the child/sibling tree table
`default_nettype none

package cstt_pkg;

    // default table size (slots 1..MAX_NODES, slot 0 means no node)
    localparam int MAX_NODES_DEF = 63;

    // width of the index and count fields on the result port
    localparam int FIELD_W = 6;

    // action codes of an input item
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    // status codes of a result item
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_PARENT = 2'd1,
        STS_FULL      = 2'd2,
        STS_NO_VALUE  = 2'd3
    } status_t;

    // which indices a result carries
    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_LOOKUP = 2'd1,
        RES_INSERT = 2'd2
    } res_kind_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_ROOT   = 3'd1,
        ST_SEARCH = 3'd2,
        ST_FC_RD  = 3'd3,
        ST_FC_CHK = 3'd4,
        ST_WALK   = 3'd5,
        ST_FINISH = 3'd6
    } state_t;

    // input item
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] node_key;
        logic [7:0] parent_key;
    } item_t;

    // result item
    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] node_index;
        logic [FIELD_W-1:0] parent_index;
        logic [FIELD_W-1:0] node_count;
    } result_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      accept;
        logic      clear;
        logic      search_start;
        logic      search_run;
        logic      node_write;
        logic      link_fc;
        logic      walk_step;
        logic      s_load;
        logic      link_ns;
        logic      commit;
        logic      res_load;
        status_t   res_status;
        res_kind_t res_kind;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic full;
        logic hit;
        logic miss;
        logic fc_zero;
        logic ns_zero;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/cstt_datapath.sv =====
// node table memories, parent search, sibling walk and result register
`default_nettype none

module cstt_datapath #(
    parameter int MAX_NODES = cstt_pkg::MAX_NODES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cstt_pkg::item_t  item,
    input  wire cstt_pkg::cmd_t   cmd,
    output cstt_pkg::stat_t       stat,
    output cstt_pkg::result_t     result,
    output logic                  result_valid,
    input  wire logic             result_stall
);

    localparam int DEPTH = MAX_NODES + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int OW    = cstt_pkg::FIELD_W;
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_NODES);
    localparam logic [IW-1:0] ONE_IDX = IW'(1);

    // node table, one entry per slot
    logic [7:0]    value_mem [DEPTH];
    logic [IW-1:0] fc_mem    [DEPTH];
    logic [IW-1:0] ns_mem    [DEPTH];

    logic [IW-1:0] count_reg;
    logic [IW-1:0] scan_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;
    logic [IW-1:0] found_reg;
    logic [IW-1:0] s_reg;
    logic [7:0]    key_reg;
    logic [7:0]    nv_reg;
    logic [7:0]    val_q_reg;
    logic [IW-1:0] fc_q_reg;
    logic [IW-1:0] ns_q_reg;
    logic          result_valid_reg;
    cstt_pkg::result_t result_reg;

    logic [IW-1:0]    n_idx;
    logic [IW-1:0]    ns_raddr;
    logic [IW-1:0]    res_node;
    logic [IW-1:0]    res_par;
    logic [IW+OW-1:0] node_ext;
    logic [IW+OW-1:0] par_ext;
    logic [IW+OW-1:0] count_ext;
    logic             out_free;

    // slot of the node being inserted
    assign n_idx = count_reg + ONE_IDX;

    // sibling read follows the first child, then each next link
    assign ns_raddr = cmd.walk_step ? ns_q_reg : fc_q_reg;

    assign out_free = !result_valid_reg || !result_stall;

    // status back to the controller
    always_comb
    begin
        stat.count_zero = (count_reg == '0);
        stat.full       = (count_reg >= MAX_IDX);
        stat.hit        = cmp_vld_reg && (val_q_reg == key_reg);
        stat.miss       = cmp_vld_reg && (val_q_reg != key_reg) && (cmp_idx_reg == count_reg);
        stat.fc_zero    = (fc_q_reg == '0);
        stat.ns_zero    = (ns_q_reg == '0);
        stat.out_free   = out_free;
    end

    // value memory: written on node creation, read by the search
    always_ff @(posedge clk)
    begin
        if (cmd.node_write)
        begin
            value_mem[n_idx] <= nv_reg;
        end
        val_q_reg <= value_mem[scan_reg];
    end

    // first-child memory
    always_ff @(posedge clk)
    begin
        if (cmd.node_write)
        begin
            fc_mem[n_idx] <= '0;
        end
        else if (cmd.link_fc)
        begin
            fc_mem[found_reg] <= n_idx;
        end
        fc_q_reg <= fc_mem[found_reg];
    end

    // next-sibling memory
    always_ff @(posedge clk)
    begin
        if (cmd.node_write)
        begin
            ns_mem[n_idx] <= '0;
        end
        else if (cmd.link_ns)
        begin
            ns_mem[s_reg] <= n_idx;
        end
        ns_q_reg <= ns_mem[ns_raddr];
    end

    // node count and search pipeline flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.search_run;
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.commit)
            begin
                count_reg <= n_idx;
            end
        end
    end

    // item latch, scan pointer, found slot and walk pointer
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_reg;
        if (cmd.accept)
        begin
            nv_reg    <= item.node_key;
            key_reg   <= (item.action == cstt_pkg::ACT_LOOKUP) ? item.node_key
                                                               : item.parent_key;
            found_reg <= '0;
        end
        else if (cmd.search_run && stat.hit)
        begin
            found_reg <= cmp_idx_reg;
        end
        if (cmd.search_start)
        begin
            scan_reg <= ONE_IDX;
        end
        else if (cmd.search_run && (scan_reg != count_reg))
        begin
            scan_reg <= scan_reg + ONE_IDX;
        end
        if (cmd.s_load)
        begin
            s_reg <= ns_raddr;
        end
    end

    // result index selection
    always_comb
    begin
        res_node = '0;
        res_par  = '0;
        case (cmd.res_kind)
            cstt_pkg::RES_LOOKUP:
            begin
                res_node = found_reg;
            end
            cstt_pkg::RES_INSERT:
            begin
                res_node = count_reg;
                res_par  = found_reg;
            end
            default:
            begin
                res_node = '0;
                res_par  = '0;
            end
        endcase
    end

    assign node_ext  = {{OW{1'b0}}, res_node};
    assign par_ext   = {{OW{1'b0}}, res_par};
    assign count_ext = {{OW{1'b0}}, count_reg};

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            result_reg.status       <= cmd.res_status;
            result_reg.node_index   <= node_ext[OW-1:0];
            result_reg.parent_index <= par_ext[OW-1:0];
            result_reg.node_count   <= count_ext[OW-1:0];
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_IDX)
        else $error("node count beyond table size");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (count_reg < MAX_IDX))
        else $error("insert committed into a full table");

    a_link_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_ns |-> ((s_reg != '0) && (s_reg <= count_reg)))
        else $error("sibling link written to an unfilled slot");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search_run && stat.hit) |-> ((cmp_idx_reg != '0) && (cmp_idx_reg <= count_reg)))
        else $error("search hit outside filled slots");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!result_valid_reg || !result_stall))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ===== hdl/cstt_ctrl.sv =====
// controller state machine sequencing insert, lookup and clear
`default_nettype none

module cstt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire logic [1:0]      action,
    input  wire cstt_pkg::stat_t stat,
    output logic                 item_stall,
    output cstt_pkg::cmd_t       cmd
);

    cstt_pkg::state_t    state_reg;
    cstt_pkg::state_t    state_next;
    logic                op_lookup_reg;
    logic                op_lookup_next;
    cstt_pkg::status_t   res_status_reg;
    cstt_pkg::status_t   res_status_next;
    cstt_pkg::res_kind_t res_kind_reg;
    cstt_pkg::res_kind_t res_kind_next;

    // state and pending result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cstt_pkg::ST_IDLE;
            op_lookup_reg  <= 1'b0;
            res_status_reg <= cstt_pkg::STS_OK;
            res_kind_reg   <= cstt_pkg::RES_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            op_lookup_reg  <= op_lookup_next;
            res_status_reg <= res_status_next;
            res_kind_reg   <= res_kind_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        op_lookup_next  = op_lookup_reg;
        res_status_next = res_status_reg;
        res_kind_next   = res_kind_reg;
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        cmd.res_kind    = res_kind_reg;
        item_stall      = (state_reg != cstt_pkg::ST_IDLE);

        case (state_reg)
            cstt_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept      = 1'b1;
                    res_status_next = cstt_pkg::STS_OK;
                    res_kind_next   = cstt_pkg::RES_NONE;
                    state_next      = cstt_pkg::ST_FINISH;
                    case (action)
                        cstt_pkg::ACT_INSERT:
                        begin
                            if (stat.full)
                            begin
                                res_status_next = cstt_pkg::STS_FULL;
                            end
                            else if (stat.count_zero)
                            begin
                                state_next = cstt_pkg::ST_ROOT;
                            end
                            else
                            begin
                                cmd.search_start = 1'b1;
                                op_lookup_next   = 1'b0;
                                state_next       = cstt_pkg::ST_SEARCH;
                            end
                        end
                        cstt_pkg::ACT_LOOKUP:
                        begin
                            if (stat.count_zero)
                            begin
                                res_status_next = cstt_pkg::STS_NO_VALUE;
                            end
                            else
                            begin
                                cmd.search_start = 1'b1;
                                op_lookup_next   = 1'b1;
                                state_next       = cstt_pkg::ST_SEARCH;
                            end
                        end
                        cstt_pkg::ACT_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            // unused action: plain ok result
                            state_next = cstt_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            cstt_pkg::ST_ROOT:
            begin
                cmd.node_write  = 1'b1;
                cmd.commit      = 1'b1;
                res_status_next = cstt_pkg::STS_OK;
                res_kind_next   = cstt_pkg::RES_INSERT;
                state_next      = cstt_pkg::ST_FINISH;
            end
            cstt_pkg::ST_SEARCH:
            begin
                cmd.search_run = 1'b1;
                if (stat.hit)
                begin
                    if (op_lookup_reg)
                    begin
                        res_status_next = cstt_pkg::STS_OK;
                        res_kind_next   = cstt_pkg::RES_LOOKUP;
                        state_next      = cstt_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = cstt_pkg::ST_FC_RD;
                    end
                end
                else if (stat.miss)
                begin
                    res_kind_next   = cstt_pkg::RES_NONE;
                    res_status_next = op_lookup_reg ? cstt_pkg::STS_NO_VALUE
                                                    : cstt_pkg::STS_NO_PARENT;
                    state_next      = cstt_pkg::ST_FINISH;
                end
            end
            cstt_pkg::ST_FC_RD:
            begin
                cmd.node_write = 1'b1;
                state_next     = cstt_pkg::ST_FC_CHK;
            end
            cstt_pkg::ST_FC_CHK:
            begin
                if (stat.fc_zero)
                begin
                    cmd.link_fc     = 1'b1;
                    cmd.commit      = 1'b1;
                    res_status_next = cstt_pkg::STS_OK;
                    res_kind_next   = cstt_pkg::RES_INSERT;
                    state_next      = cstt_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.s_load = 1'b1;
                    state_next = cstt_pkg::ST_WALK;
                end
            end
            cstt_pkg::ST_WALK:
            begin
                if (stat.ns_zero)
                begin
                    cmd.link_ns     = 1'b1;
                    cmd.commit      = 1'b1;
                    res_status_next = cstt_pkg::STS_OK;
                    res_kind_next   = cstt_pkg::RES_INSERT;
                    state_next      = cstt_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.s_load    = 1'b1;
                end
            end
            cstt_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = cstt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cstt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/child_sibling_tree_table.sv =====
// top level of the first-child / next-sibling tree table
//
//   channel   direction  handshake             payload
//   item      in         item_valid/item_stall  cstt_pkg::item_t
//   result    out        result_valid/_stall    cstt_pkg::result_t
//
// one item at a time. clear, unused action, empty lookup and full insert go
// straight to the result; a root insert first writes slot 1. the search reads
// one slot a cycle from slot 1: a lookup ends at the hit slot, a miss or a missing
// parent at the last filled slot, and a linked insert then walks the parent's children.
// reset empties the table at once; the node memories need no clearing pass.
// a stalled result holds back the next result; the next item is still taken.
`default_nettype none

module child_sibling_tree_table #(
    parameter int MAX_NODES = cstt_pkg::MAX_NODES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire cstt_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output cstt_pkg::result_t      result
);

    cstt_pkg::cmd_t  cmd;
    cstt_pkg::stat_t stat;

    // sequencing
    cstt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .action     (item.action),
        .stat       (stat),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // table and result datapath
    cstt_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire
